// ===== rtl/core/mexp_pkg.sv =====
// shared constants and types for the modular exponentiation block
package mexp_pkg;

    localparam int FIELD_BITS     = 32;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 1'b1;

    localparam logic [CFG_DATA_BITS-1:0] EXPONENT_RESET = 32'd1;
    localparam logic [CFG_DATA_BITS-1:0] MODULUS_RESET  = 32'd3233;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

endpackage

// ===== rtl/core/mexp_if.sv =====
// valid/ready channel interfaces for base values and results
interface mexp_in_if;
    logic                             valid;
    logic                             ready;
    logic [mexp_pkg::FIELD_BITS-1:0]  base_value;

    modport source (output valid, output base_value, input ready);
    modport sink   (input valid, input base_value, output ready);
endinterface

interface mexp_out_if;
    logic                             valid;
    logic                             ready;
    logic [mexp_pkg::FIELD_BITS-1:0]  power_result;
    logic                             base_too_large;

    modport source (output valid, output power_result, output base_too_large, input ready);
    modport sink   (input valid, input power_result, input base_too_large, output ready);
endinterface

// ===== rtl/core/modular_exponentiation.sv =====
// modular exponentiation top level, right-to-left square and multiply
//
//   channel      dir   handshake        payload
//   base_in      in    valid/ready      base_value[31:0]
//   result_out   out   valid/ready      power_result[31:0], base_too_large
//   cfg          in    cfg_we           cfg_index[0], cfg_data[31:0]
//
// one item: the base is first reduced mod m, then each exponent bit takes a check
// state, a multiply for a set bit and a square (none after the top bit); each
// reduction, multiply and square runs on the bit-serial multiplier
// modulus below 2 returns 0 without using the multiplier, zero exponent returns 1
// reset loads exponent 1 and modulus 3233, no clearing pass
// base_in is ready only when idle; one finished result waits in the output register
module modular_exponentiation #(
    parameter int OPERAND_BITS = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [mexp_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [mexp_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    mexp_in_if.sink                                   base_in,
    mexp_out_if.source                                result_out
);

    localparam int W = OPERAND_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MULT,
        ST_SQUARE,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [mexp_pkg::CFG_DATA_BITS-1:0] exponent_reg;
    logic [mexp_pkg::CFG_DATA_BITS-1:0] modulus_reg;

    logic [W-1:0] exp_reg;
    logic [W-1:0] m_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] pw_reg;
    logic         flag_reg;
    logic         mul_start_reg;

    logic                            out_valid_reg;
    logic [mexp_pkg::FIELD_BITS-1:0] out_result_reg;
    logic                            out_flag_reg;

    logic [W-1:0] base_w;
    logic [W-1:0] exp_w;
    logic [W-1:0] mod_w;

    logic [W-1:0] mul_a;
    logic [W-1:0] mul_b;
    logic [W-1:0] mul_result;
    mexp_pkg::mul_status_t mul_status;

    assign base_w = base_in.base_value[W-1:0];
    assign exp_w  = exponent_reg[W-1:0];
    assign mod_w  = modulus_reg[W-1:0];

    always_comb
    begin
        case (state_reg)
            ST_MULT:
            begin
                mul_a = acc_reg;
                mul_b = pw_reg;
            end
            ST_SQUARE:
            begin
                mul_a = pw_reg;
                mul_b = pw_reg;
            end
            default:
            begin
                mul_a = W'(1);
                mul_b = pw_reg;
            end
        endcase
    end

    mexp_mulmod #(
        .OPERAND_BITS (W)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start_reg),
        .a      (mul_a),
        .b      (mul_b),
        .m      (m_reg),
        .result (mul_result),
        .status (mul_status)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= mexp_pkg::EXPONENT_RESET;
            modulus_reg  <= mexp_pkg::MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mexp_pkg::REG_EXPONENT: exponent_reg <= cfg_data;
                mexp_pkg::REG_MODULUS:  modulus_reg  <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mul_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (base_in.valid)
                    begin
                        m_reg    <= mod_w;
                        exp_reg  <= exp_w;
                        pw_reg   <= base_w;
                        flag_reg <= (base_w >= mod_w);
                        if (mod_w < W'(2))
                        begin
                            acc_reg   <= '0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            acc_reg       <= W'(1);
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE:
                begin
                    if (mul_status.done)
                    begin
                        pw_reg    <= mul_result;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (exp_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else if (exp_reg[0])
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MULT;
                    end
                    else
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_SQUARE;
                    end
                end
                ST_MULT:
                begin
                    if (mul_status.done)
                    begin
                        acc_reg <= mul_result;
                        // last exponent bit: the final square is not needed
                        if ((exp_reg >> 1) == '0)
                        begin
                            exp_reg   <= '0;
                            state_reg <= ST_CHECK;
                        end
                        else
                        begin
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_SQUARE;
                        end
                    end
                end
                ST_SQUARE:
                begin
                    if (mul_status.done)
                    begin
                        pw_reg    <= mul_result;
                        exp_reg   <= exp_reg >> 1;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || result_out.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_result_reg <= mexp_pkg::FIELD_BITS'(acc_reg);
                        out_flag_reg   <= flag_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign base_in.ready             = (state_reg == ST_IDLE);
    assign result_out.valid          = out_valid_reg;
    assign result_out.power_result   = out_result_reg;
    assign result_out.base_too_large = out_flag_reg;

    // no new item while the multiplier is running
    assert property (@(posedge clk) disable iff (!rst_n)
        base_in.ready |-> !mul_status.busy)
        else $error("input ready while multiplier busy");

    // multiplier is only started when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_start_reg |-> !mul_status.busy)
        else $error("multiplier started while busy");

    // running product always reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && m_reg >= W'(2)) |-> (acc_reg < m_reg))
        else $error("accumulator not below modulus");

    // a result appears only on leaving the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_out.valid) |-> $past(state_reg == ST_DONE))
        else $error("result valid without finished item");

endmodule

// ===== rtl/core/mexp_mulmod.sv =====
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
module mexp_mulmod #(
    parameter int OPERAND_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [OPERAND_BITS-1:0]   a,
    input  logic [OPERAND_BITS-1:0]   b,
    input  logic [OPERAND_BITS-1:0]   m,
    output logic [OPERAND_BITS-1:0]   result,
    output mexp_pkg::mul_status_t     status
);

    localparam int CNT_BITS = $clog2(OPERAND_BITS);
    localparam int WIDE     = OPERAND_BITS + 2;

    logic [OPERAND_BITS-1:0] b_reg;
    logic [OPERAND_BITS-1:0] r_reg;
    logic [OPERAND_BITS-1:0] r_next;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic [WIDE-1:0] sum;
    logic [WIDE-1:0] m_once;
    logic [WIDE-1:0] m_twice;

    // r = (2r + bit*a) mod m, sum stays below 3m since r, a < m
    always_comb
    begin
        m_once  = {2'b00, m};
        m_twice = {1'b0, m, 1'b0};
        sum     = {1'b0, r_reg, 1'b0} + (b_reg[OPERAND_BITS-1] ? {2'b00, a} : '0);
        if (sum >= m_twice)
        begin
            r_next = OPERAND_BITS'(sum - m_twice);
        end
        else if (sum >= m_once)
        begin
            r_next = OPERAND_BITS'(sum - m_once);
        end
        else
        begin
            r_next = OPERAND_BITS'(sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                b_reg    <= b;
                r_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                r_reg   <= r_next;
                b_reg   <= b_reg << 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(OPERAND_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign result      = r_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
